[rtl/efl_pkg.sv]
// Shared types and constants for the electric field limiter.
// Field widths, payload structs and mode codes; no dependencies.
`timescale 1ns / 1ps

package efl_pkg;

   localparam int FIELD_W = 24;
   localparam int MAG_W   = FIELD_W;
   localparam int SQ_W    = 2 * FIELD_W;
   localparam int NUM_W   = 3 * FIELD_W;
   localparam int ROOT_W  = FIELD_W;
   localparam int Q_W     = FIELD_W + 1;

   localparam logic MODE_SHRINK = 1'b0;
   localparam logic MODE_CLEAN  = 1'b1;

   typedef logic signed [FIELD_W-1:0] field_type;

   typedef struct packed {
      field_type b_x;
      field_type b_y;
      field_type b_z;
      field_type e_x;
      field_type e_y;
      field_type e_z;
   } req_type;

   typedef struct packed {
      field_type new_e_x;
      field_type new_e_y;
      field_type new_e_z;
      logic      changed;
      logic      zero_field;
      logic      saturated;
   } rsp_type;

endpackage

[rtl/electric_field_limiter.sv]
// Electric field limiter: pipelined correction of E against B per grid cell.
// Depends on efl_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   req channel carries one cell (B and E, three signed components each).
//   rsp channel returns the corrected E and the changed, zero_field and
//   saturated flags. Both use valid/stall; a transaction moves on a rising
//   edge with valid high and stall low.
//   csr_write_enable/csr_write_data set the mode (0 shrink, 1 clean); write
//   it only while no transaction is in flight.
// Throughput: one transaction per cycle while rsp_stall does not hold the pipeline.
// Pipeline length is set mostly by the bit-per-stage square root
//   (FIELD_W stages) and the bit-per-stage divider (FIELD_W+1 stages).
// Reset clears all valid bits and sets shrink mode.
// When rsp_stall is high with a result pending, the whole pipeline holds
//   and req_stall is raised in the same cycle; nothing is lost or repeated.

module electric_field_limiter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  efl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output efl_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);
   import efl_pkg::*;

   typedef struct packed {
      logic                      mode;
      logic                      shr;
      logic                      zero;
      logic                      ebneg;
      logic [2:0]                bneg;
      logic [2:0]                eneg;
      logic [2:0][FIELD_W-1:0]   e;
      logic [2:0][MAG_W-1:0]     bm;
      logic [2:0][MAG_W-1:0]     em;
      logic [SQ_W-1:0]           b2;
      logic [SQ_W-1:0]           e2;
      logic [2:0][NUM_W-1:0]     num;
   } ctx_type;

   function automatic logic [MAG_W-1:0] mag_f(input logic [FIELD_W-1:0] v);
      logic [MAG_W-1:0] u;
      u = v;
      mag_f = v[FIELD_W-1] ? (~u + 1'b1) : u;
   endfunction

   logic en;
   logic mode_ff;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SHRINK;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   logic [FIELD_W-1:0] bin [3];
   logic [FIELD_W-1:0] ein [3];
   assign bin[0] = req_data.b_x;
   assign bin[1] = req_data.b_y;
   assign bin[2] = req_data.b_z;
   assign ein[0] = req_data.e_x;
   assign ein[1] = req_data.e_y;
   assign ein[2] = req_data.e_z;

   // stage 1: magnitudes and signs
   logic               v1_ff, m1_ff;
   logic [FIELD_W-1:0] e1_ff [3];
   logic [MAG_W-1:0]   bm1_ff [3], em1_ff [3];
   logic               bs1_ff [3], es1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
      if (en) begin
         m1_ff <= mode_ff;
         for (int d = 0; d < 3; d++) begin
            e1_ff[d]  <= ein[d];
            bm1_ff[d] <= mag_f(bin[d]);
            em1_ff[d] <= mag_f(ein[d]);
            bs1_ff[d] <= bin[d][FIELD_W-1];
            es1_ff[d] <= ein[d][FIELD_W-1];
         end
      end
   end

   // stage 2: squares and per-component B*E products
   logic               v2_ff, m2_ff;
   logic [FIELD_W-1:0] e2r_ff [3];
   logic [MAG_W-1:0]   bm2_ff [3], em2_ff [3];
   logic               bs2_ff [3], es2_ff [3];
   logic [SQ_W-1:0]    bb2_ff [3], ee2_ff [3], be2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         m2_ff <= m1_ff;
         for (int d = 0; d < 3; d++) begin
            e2r_ff[d] <= e1_ff[d];
            bm2_ff[d] <= bm1_ff[d];
            em2_ff[d] <= em1_ff[d];
            bs2_ff[d] <= bs1_ff[d];
            es2_ff[d] <= es1_ff[d];
            bb2_ff[d] <= bm1_ff[d] * bm1_ff[d];
            ee2_ff[d] <= em1_ff[d] * em1_ff[d];
            be2_ff[d] <= bm1_ff[d] * em1_ff[d];
         end
      end
   end

   // stage 3: sums
   logic               v3_ff, m3_ff;
   logic [FIELD_W-1:0] e3_ff [3];
   logic [MAG_W-1:0]   bm3_ff [3], em3_ff [3];
   logic               bs3_ff [3], es3_ff [3];
   logic [SQ_W-1:0]    b2s3_ff, e2s3_ff, pos3_ff, neg3_ff;
   logic [SQ_W-1:0]    pos_in, neg_in;

   always_comb begin
      pos_in = '0;
      neg_in = '0;
      for (int d = 0; d < 3; d++) begin
         if (bs2_ff[d] != es2_ff[d]) begin
            neg_in = neg_in + be2_ff[d];
         end else begin
            pos_in = pos_in + be2_ff[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         m3_ff   <= m2_ff;
         b2s3_ff <= bb2_ff[0] + bb2_ff[1] + bb2_ff[2];
         e2s3_ff <= ee2_ff[0] + ee2_ff[1] + ee2_ff[2];
         pos3_ff <= pos_in;
         neg3_ff <= neg_in;
         for (int d = 0; d < 3; d++) begin
            e3_ff[d]  <= e2r_ff[d];
            bm3_ff[d] <= bm2_ff[d];
            em3_ff[d] <= em2_ff[d];
            bs3_ff[d] <= bs2_ff[d];
            es3_ff[d] <= es2_ff[d];
         end
      end
   end

   // stage 4: dot product magnitude, compares
   logic            v4_ff;
   ctx_type         c4_ff;
   logic [SQ_W-1:0] ebm4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         c4_ff.mode  <= m3_ff;
         c4_ff.shr   <= e2s3_ff > b2s3_ff;
         c4_ff.zero  <= b2s3_ff == '0;
         c4_ff.ebneg <= neg3_ff > pos3_ff;
         c4_ff.b2    <= b2s3_ff;
         c4_ff.e2    <= e2s3_ff;
         c4_ff.num   <= '0;
         ebm4_ff     <= (neg3_ff > pos3_ff) ? (neg3_ff - pos3_ff) : (pos3_ff - neg3_ff);
         for (int d = 0; d < 3; d++) begin
            c4_ff.bneg[d] <= bs3_ff[d];
            c4_ff.eneg[d] <= es3_ff[d];
            c4_ff.e[d]    <= e3_ff[d];
            c4_ff.bm[d]   <= bm3_ff[d];
            c4_ff.em[d]   <= em3_ff[d];
         end
      end
   end

   // stage 5: partial products of the clean numerator
   logic            v5_ff;
   ctx_type         c5_ff;
   logic [SQ_W-1:0] plo5_ff [3], phi5_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         c5_ff <= c4_ff;
         for (int d = 0; d < 3; d++) begin
            plo5_ff[d] <= ebm4_ff[FIELD_W-1:0] * c4_ff.bm[d];
            phi5_ff[d] <= ebm4_ff[SQ_W-1:FIELD_W] * c4_ff.bm[d];
         end
      end
   end

   // stage 6 and square root stages
   logic              sv_ff [ROOT_W+1];
   ctx_type           sc_ff [ROOT_W+1];
   logic [SQ_W:0]     rb_ff [ROOT_W+1], re_ff [ROOT_W+1];
   logic [ROOT_W-1:0] nb_ff [ROOT_W+1], ne_ff [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= v5_ff;
      end
      if (en) begin
         sc_ff[0].mode  <= c5_ff.mode;
         sc_ff[0].shr   <= c5_ff.shr;
         sc_ff[0].zero  <= c5_ff.zero;
         sc_ff[0].ebneg <= c5_ff.ebneg;
         sc_ff[0].bneg  <= c5_ff.bneg;
         sc_ff[0].eneg  <= c5_ff.eneg;
         sc_ff[0].e     <= c5_ff.e;
         sc_ff[0].bm    <= c5_ff.bm;
         sc_ff[0].em    <= c5_ff.em;
         sc_ff[0].b2    <= c5_ff.b2;
         sc_ff[0].e2    <= c5_ff.e2;
         for (int d = 0; d < 3; d++) begin
            sc_ff[0].num[d] <= NUM_W'(plo5_ff[d]) + (NUM_W'(phi5_ff[d]) << FIELD_W);
         end
         rb_ff[0] <= {1'b0, c5_ff.b2};
         re_ff[0] <= {1'b0, c5_ff.e2};
         nb_ff[0] <= '0;
         ne_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      localparam int BI = ROOT_W - 1 - k;
      logic [SQ_W:0] tb, te;
      assign tb = ((SQ_W+1)'(nb_ff[k]) << (BI + 1)) | ((SQ_W+1)'(1) << (2 * BI));
      assign te = ((SQ_W+1)'(ne_ff[k]) << (BI + 1)) | ((SQ_W+1)'(1) << (2 * BI));

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (en) begin
            sv_ff[k+1] <= sv_ff[k];
         end
         if (en) begin
            sc_ff[k+1] <= sc_ff[k];
            if (rb_ff[k] >= tb) begin
               rb_ff[k+1] <= rb_ff[k] - tb;
               nb_ff[k+1] <= nb_ff[k] | (ROOT_W'(1) << BI);
            end else begin
               rb_ff[k+1] <= rb_ff[k];
               nb_ff[k+1] <= nb_ff[k];
            end
            if (re_ff[k] >= te) begin
               re_ff[k+1] <= re_ff[k] - te;
               ne_ff[k+1] <= ne_ff[k] | (ROOT_W'(1) << BI);
            end else begin
               re_ff[k+1] <= re_ff[k];
               ne_ff[k+1] <= ne_ff[k];
            end
         end
      end
   end

   // divider setup and divider stages
   logic                  dv_ff [Q_W+1];
   ctx_type               dc_ff [Q_W+1];
   logic [2:0][NUM_W-1:0] dn_ff [Q_W+1];
   logic [SQ_W-1:0]       dd_ff [Q_W+1];
   logic [2:0][Q_W-1:0]   dq_ff [Q_W+1];
   logic [SQ_W-1:0]       sp [3];

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         sp[d] = sc_ff[ROOT_W].em[d] * nb_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= sv_ff[ROOT_W];
      end
      if (en) begin
         dc_ff[0] <= sc_ff[ROOT_W];
         dq_ff[0] <= '0;
         if (sc_ff[ROOT_W].mode == MODE_SHRINK) begin
            dd_ff[0] <= SQ_W'(ne_ff[ROOT_W]);
            for (int d = 0; d < 3; d++) begin
               dn_ff[0][d] <= NUM_W'(sp[d]);
            end
         end else begin
            dd_ff[0] <= sc_ff[ROOT_W].b2;
            dn_ff[0] <= sc_ff[ROOT_W].num;
         end
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      localparam int QI = Q_W - 1 - k;
      logic [NUM_W:0] sh;
      assign sh = (NUM_W+1)'(dd_ff[k]) << QI;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_ff[k+1] <= dv_ff[k];
         end
         if (en) begin
            dc_ff[k+1] <= dc_ff[k];
            dd_ff[k+1] <= dd_ff[k];
            for (int d = 0; d < 3; d++) begin
               if ({1'b0, dn_ff[k][d]} >= sh) begin
                  dn_ff[k+1][d] <= dn_ff[k][d] - sh[NUM_W-1:0];
                  dq_ff[k+1][d] <= dq_ff[k][d] | (Q_W'(1) << QI);
               end else begin
                  dn_ff[k+1][d] <= dn_ff[k][d];
                  dq_ff[k+1][d] <= dq_ff[k][d];
               end
            end
         end
      end
   end

   // result formation and output register
   logic [FIELD_W-1:0] r_in [3];
   logic               sat_in, chg_in, zero_in;

   always_comb begin
      logic [FIELD_W+2:0] ext_e, ext_q, cv;
      logic [FIELD_W-1:0] qn;
      ctx_type            c;
      c       = dc_ff[Q_W];
      sat_in  = 1'b0;
      chg_in  = 1'b0;
      zero_in = (c.mode == MODE_CLEAN) && c.zero;
      for (int d = 0; d < 3; d++) begin
         qn    = dq_ff[Q_W][d][FIELD_W-1:0];
         ext_e = {{3{c.e[d][FIELD_W-1]}}, c.e[d]};
         ext_q = {2'b00, dq_ff[Q_W][d]};
         cv    = (c.ebneg != c.bneg[d]) ? (ext_e + ext_q) : (ext_e - ext_q);
         r_in[d] = c.e[d];
         if (c.mode == MODE_SHRINK) begin
            if (c.shr) begin
               r_in[d] = c.eneg[d] ? (~qn + 1'b1) : qn;
            end
         end else if (!c.zero) begin
            if (!cv[FIELD_W+2] && (cv[FIELD_W+2:FIELD_W-1] != '0)) begin
               r_in[d] = {1'b0, {(FIELD_W-1){1'b1}}};
               sat_in  = 1'b1;
            end else if (cv[FIELD_W+2] && (cv[FIELD_W+2:FIELD_W-1] != '1)) begin
               r_in[d] = {1'b1, {(FIELD_W-1){1'b0}}};
               sat_in  = 1'b1;
            end else begin
               r_in[d] = cv[FIELD_W-1:0];
            end
         end
         if (r_in[d] != c.e[d]) begin
            chg_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ff[Q_W];
      end
      if (en) begin
         rsp_data_ff.new_e_x    <= r_in[0];
         rsp_data_ff.new_e_y    <= r_in[1];
         rsp_data_ff.new_e_z    <= r_in[2];
         rsp_data_ff.changed    <= chg_in;
         rsp_data_ff.zero_field <= zero_in;
         rsp_data_ff.saturated  <= sat_in;
      end
   end

endmodule
